/* src/mrbm_pkg.sv */
// ----------------------------------------------------------------------------
// mrbm_pkg: shared types and constants of the maximal rectangle block
// Area width and saturation value, and the control group of the area unit.
// ----------------------------------------------------------------------------
package mrbm_pkg;

	localparam int unsigned AREA_W = 17;
	localparam int unsigned NCOL_W = 7;
	localparam logic [AREA_W-1:0] AREA_MAX = '1;

	typedef struct packed {
		logic load;
		logic accum;
		logic clear;
	} area_ctrl_t;

endpackage

/* src/mrbm_ram.sv */
// ----------------------------------------------------------------------------
// mrbm_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mrbm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/mrbm_area_unit.sv */
// ----------------------------------------------------------------------------
// mrbm_area_unit: shared area multiplier and running maximum
// Registers height times width, saturates it and keeps the largest area.
// ----------------------------------------------------------------------------
module mrbm_area_unit #(
	parameter int unsigned HW = 11,
	parameter int unsigned NW = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mrbm_pkg::area_ctrl_t          ctrl,
	input  logic [HW-1:0]                 height,
	input  logic [NW-1:0]                 width,
	output logic [mrbm_pkg::AREA_W-1:0]   best
);

	localparam int unsigned PW = HW + NW;
	localparam int unsigned AW = mrbm_pkg::AREA_W;

	logic [PW-1:0] prod_c;
	logic [PW-1:0] prod_s1;
	logic [AW-1:0] sat_c;
	logic [AW-1:0] best_q;

	assign prod_c = {{NW{1'b0}}, height} * {{HW{1'b0}}, width};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prod_s1 <= prod_c;
		end
	end

	assign sat_c = (64'(prod_s1) > 64'(mrbm_pkg::AREA_MAX)) ? mrbm_pkg::AREA_MAX
		: AW'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (ctrl.clear) begin
			best_q <= '0;
		end else if (ctrl.accum && (sat_c > best_q)) begin
			best_q <= sat_c;
		end
	end

	assign best = best_q;

endmodule

/* src/maximal_rectangle_binary_matrix.sv */
// ----------------------------------------------------------------------------
// maximal_rectangle_binary_matrix: largest all-ones rectangle of a matrix
// Column histogram with a monotonic stack sweep at the end of every row.
// ----------------------------------------------------------------------------
// usage
//   cells arrive one per item in row-major order: start with cell_is_one
//   and last_cell is taken at a clock edge where busy is low.
//   num_cols_we writes num_cols (columns per row, 0 acts as 1, values above
//   MAX_COLS act as MAX_COLS); write it only while busy is low.
//   a cell that does not end a row keeps busy high for one cycle. a cell
//   that ends a row of n columns, or carries last_cell, starts a sweep that
//   keeps busy high until it ends. the sweep is bound by the single
//   multiplier/compare unit and the one access per cycle of the stack and
//   histogram memories.
//   on a last_cell item, done pulses with max_area in the first cycle that
//   busy is low; the histogram and maximum are then cleared.
//   the receiver cannot stall: done is a one-cycle strobe.
//   reset clears the histogram (per-column valid bits), the maximum, the
//   column position, and sets num_cols to 64. no clearing pass is needed.
// ----------------------------------------------------------------------------
module maximal_rectangle_binary_matrix #(
	parameter int unsigned MAX_COLS = 64,
	parameter int unsigned MAX_ROWS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                cell_is_one,
	input  logic                                last_cell,
	input  logic                                num_cols_we,
	input  logic [mrbm_pkg::NCOL_W-1:0]         num_cols,
	output logic                                done,
	output logic [mrbm_pkg::AREA_W-1:0]         max_area
);

	localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned NW  = $clog2(MAX_COLS + 1);
	localparam int unsigned HW  = $clog2(MAX_ROWS + 1);
	localparam int unsigned SEW = HW + CW;
	localparam int unsigned AW  = mrbm_pkg::AREA_W;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_UPD  = 7'b0000010,
		ST_RD   = 7'b0000100,
		ST_LOAD = 7'b0001000,
		ST_CHK  = 7'b0010000,
		ST_POP  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t                     state_q;
	logic [mrbm_pkg::NCOL_W-1:0] ncols_q;
	logic [CW-1:0]              pos_q;
	logic [MAX_COLS-1:0]        vld_q;
	logic                       cell_q;
	logic                       last_q;
	logic [NW-1:0]              n_q;
	logic [NW-1:0]              i_q;
	logic [NW-1:0]              d_q;
	logic [HW-1:0]              h_q;
	logic [CW-1:0]              start_q;
	logic [HW-1:0]              top_h_q;
	logic [CW-1:0]              top_start_q;
	logic                       done_q;
	logic [AW-1:0]              max_area_q;

	logic [NW-1:0]              n_eff;
	logic [NW-1:0]              pos_p1;
	logic                       row_end;
	logic [HW-1:0]              h_old;
	logic [HW-1:0]              h_new;
	logic [HW-1:0]              h_load;
	logic [NW-1:0]              i_nx;
	logic [NW-1:0]              d_m1;
	logic [NW-1:0]              d_m2;
	logic                       pop_c;
	logic                       push_c;

	logic [CW-1:0]              hram_raddr;
	logic [HW-1:0]              hram_rdata;
	logic [SEW-1:0]             sram_rdata;
	logic                       sram_we;

	mrbm_pkg::area_ctrl_t       area_ctrl;
	logic [AW-1:0]              best;

	// effective row width
	always_comb begin
		if (ncols_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(ncols_q) > MAX_COLS) begin
			n_eff = NW'(MAX_COLS);
		end else begin
			n_eff = NW'(ncols_q);
		end
	end

	assign pos_p1  = NW'(pos_q) + NW'(1);
	assign row_end = last_q || (pos_p1 >= n_eff);
	assign h_old   = vld_q[pos_q] ? hram_rdata : '0;
	assign h_new   = !cell_q ? '0
		: (h_old < HW'(MAX_ROWS)) ? (h_old + HW'(1)) : HW'(MAX_ROWS);
	assign h_load  = ((i_q < n_q) && vld_q[i_q[CW-1:0]]) ? hram_rdata : '0;
	assign i_nx    = i_q + NW'(1);
	assign d_m1    = d_q - NW'(1);
	assign d_m2    = d_q - NW'(2);

	assign pop_c  = (state_q == ST_CHK) && (d_q != '0) && (top_h_q >= h_q);
	assign push_c = (state_q == ST_CHK) && !pop_c && (i_q < n_q);

	always_comb begin
		unique case (state_q)
			ST_IDLE: hram_raddr = pos_q;
			ST_CHK:  hram_raddr = i_nx[CW-1:0];
			default: hram_raddr = i_q[CW-1:0];
		endcase
	end

	assign sram_we = push_c && (d_q != '0);

	always_comb begin
		area_ctrl.load  = pop_c;
		area_ctrl.accum = (state_q == ST_POP);
		area_ctrl.clear = (state_q == ST_FIN) && last_q;
	end

	// column heights
	mrbm_ram #(
		.WIDTH(HW),
		.DEPTH(MAX_COLS)
	) u_hist_ram (
		.clk   (clk),
		.we    (state_q == ST_UPD),
		.waddr (pos_q),
		.wdata (h_new),
		.re    (1'b1),
		.raddr (hram_raddr),
		.rdata (hram_rdata)
	);

	// bar stack below the top entry: {height, left start}
	mrbm_ram #(
		.WIDTH(SEW),
		.DEPTH(MAX_COLS)
	) u_stack_ram (
		.clk   (clk),
		.we    (sram_we),
		.waddr (d_m1[CW-1:0]),
		.wdata ({top_h_q, top_start_q}),
		.re    (pop_c),
		.raddr (d_m2[CW-1:0]),
		.rdata (sram_rdata)
	);

	mrbm_area_unit #(
		.HW(HW),
		.NW(NW)
	) u_area (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (area_ctrl),
		.height (top_h_q),
		.width  (i_q - NW'(top_start_q)),
		.best   (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ncols_q <= mrbm_pkg::NCOL_W'(64);
			pos_q   <= '0;
			vld_q   <= '0;
			n_q     <= NW'(1);
			i_q     <= '0;
			d_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN) && last_q;
			if (num_cols_we) begin
				ncols_q <= num_cols;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					vld_q[pos_q] <= 1'b1;
					if (row_end) begin
						n_q     <= pos_p1;
						i_q     <= '0;
						d_q     <= '0;
						state_q <= ST_RD;
					end else begin
						pos_q   <= pos_q + CW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (pop_c) begin
						d_q     <= d_m1;
						state_q <= ST_POP;
					end else if (push_c) begin
						d_q     <= d_q + NW'(1);
						i_q     <= i_nx;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_POP: begin
					state_q <= ST_CHK;
				end
				ST_FIN: begin
					pos_q <= '0;
					if (last_q) begin
						vld_q <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			cell_q <= cell_is_one;
			last_q <= last_cell;
		end
		if (state_q == ST_LOAD) begin
			h_q     <= h_load;
			start_q <= i_q[CW-1:0];
		end
		if (pop_c) begin
			start_q <= top_start_q;
		end
		if (push_c) begin
			top_h_q     <= h_q;
			top_start_q <= start_q;
		end
		if ((state_q == ST_POP) && (d_q != '0)) begin
			{top_h_q, top_start_q} <= sram_rdata;
		end
		if ((state_q == ST_FIN) && last_q) begin
			max_area_q <= best;
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign max_area = max_area_q;

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(last_q) && $past(state_q == ST_FIN))
		else $error("result without a last item");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(d_q <= i_q) && (i_q <= n_q))
		else $error("stack depth beyond sweep position");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item accepted without going busy");

endmodule

/* dv/tb_maximal_rectangle_binary_matrix.sv */
// ----------------------------------------------------------------------------
// tb_maximal_rectangle_binary_matrix: self-checking bench of the rectangle block
// Streams binary matrices cell by cell under bursty start timing, predicts
// the largest all-ones rectangle area of each matrix with a histogram and
// index stack model, and compares every done strobe with the oldest area.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_maximal_rectangle_binary_matrix;

	localparam int unsigned COLS_MAX    = 64;
	localparam int unsigned ROWS_MAX    = 1024;
	localparam int unsigned SWEEP_WAIT  = 4 * COLS_MAX + 24;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned ITEM_GOAL   = 1550;
	localparam int unsigned REPORT_MAX  = 10;

	class area_scoreboard;
		bit [10:0]                   height [COLS_MAX];
		bit [mrbm_pkg::NCOL_W-1:0]   cols_reg;
		int unsigned                 col_pos;
		bit [mrbm_pkg::AREA_W-1:0]   best;
		bit [mrbm_pkg::AREA_W-1:0]   area_q [$];
		int unsigned                 mismatches;

		function new();
			foreach (height[i]) height[i] = '0;
			cols_reg   = 7'd64;
			col_pos    = 0;
			best       = '0;
			mismatches = 0;
		endfunction

		function void set_cols(bit [mrbm_pkg::NCOL_W-1:0] v);
			cols_reg = v;
		endfunction

		function int unsigned pending();
			return area_q.size();
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= REPORT_MAX) $display("%s", msg);
		endfunction

		// largest rectangle under bars 0..n-1
		function bit [mrbm_pkg::AREA_W-1:0] histogram_area(int unsigned n);
			int unsigned       stk [COLS_MAX+1];
			int unsigned       depth;
			int unsigned       top;
			int unsigned       left;
			int unsigned       h;
			longint unsigned   best_here;
			longint unsigned   area;
			depth     = 0;
			best_here = 0;
			for (int unsigned i = 0; i <= n; i++) begin
				h = (i < n) ? height[i] : 0;
				while (depth > 0 && height[stk[depth-1]] >= h) begin
					top = stk[depth-1];
					depth--;
					left = (depth > 0) ? stk[depth-1] + 1 : 0;
					area = longint'(height[top]) * (i - left);
					if (area > best_here) best_here = area;
				end
				if (i < n) begin
					stk[depth] = i;
					depth++;
				end
			end
			if (best_here > mrbm_pkg::AREA_MAX) return mrbm_pkg::AREA_MAX;
			return best_here[mrbm_pkg::AREA_W-1:0];
		endfunction

		function void note_cell(bit c, bit l);
			int unsigned                 n;
			int unsigned                 pos;
			bit [mrbm_pkg::AREA_W-1:0]   a;
			n = (cols_reg == 0) ? 1 : (cols_reg > COLS_MAX) ? COLS_MAX : cols_reg;
			pos = (col_pos >= COLS_MAX) ? COLS_MAX - 1 : col_pos;
			if (c) begin
				if (height[pos] < ROWS_MAX) height[pos]++;
			end else begin
				height[pos] = '0;
			end
			if (l || pos + 1 >= n) begin
				a = histogram_area(pos + 1);
				if (a > best) best = a;
				col_pos = 0;
			end else begin
				col_pos = pos + 1;
			end
			if (l) begin
				area_q.push_back(best);
				foreach (height[i]) height[i] = '0;
				best    = '0;
				col_pos = 0;
			end
		endfunction

		function void check_area(logic [mrbm_pkg::AREA_W-1:0] got);
			bit [mrbm_pkg::AREA_W-1:0] want;
			if (area_q.size() == 0) begin
				flag($sformatf("unexpected max_area %0d with no item pending", got));
			end else begin
				want = area_q.pop_front();
				if (got !== want)
					flag($sformatf("max_area: expected %0d, got %0d", want, got));
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          cell_is_one;
	logic                          last_cell;
	logic                          num_cols_we;
	logic [mrbm_pkg::NCOL_W-1:0]   num_cols;
	logic                          done;
	logic [mrbm_pkg::AREA_W-1:0]   max_area;

	area_scoreboard  sb;
	int unsigned     burst_left;
	int unsigned     items_sent;
	int unsigned     quiet;
	int unsigned     cur_cols;

	maximal_rectangle_binary_matrix #(
		.MAX_COLS(COLS_MAX),
		.MAX_ROWS(ROWS_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cell_is_one(cell_is_one),
		.last_cell(last_cell),
		.num_cols_we(num_cols_we),
		.num_cols(num_cols),
		.done(done),
		.max_area(max_area)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_area(max_area);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_cell(bit c, bit l);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 20);
		end
		burst_left--;
		start       <= 1'b1;
		cell_is_one <= c;
		last_cell   <= l;
		do @(posedge clk); while (busy);
		sb.note_cell(c, l);
		items_sent++;
		@(negedge clk);
	endtask

	// block idle: all areas in, and any row sweep finished
	task automatic write_cols(bit [mrbm_pkg::NCOL_W-1:0] v);
		start <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SWEEP_WAIT) @(negedge clk);
		num_cols_we <= 1'b1;
		num_cols    <= v;
		@(negedge clk);
		num_cols_we <= 1'b0;
		sb.set_cols(v);
		cur_cols = v;
	endtask

	initial begin
		int unsigned  w;
		int unsigned  n;
		int unsigned  total;
		int unsigned  split_at;
		int unsigned  density;
		bit [2:0]     mat [9];

		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		cell_is_one = 1'b0;
		last_cell   = 1'b0;
		num_cols_we = 1'b0;
		num_cols    = '0;
		burst_left  = 0;
		items_sent  = 0;
		quiet       = 0;
		cur_cols    = COLS_MAX;
		sb          = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: small 3x3 matrix
		write_cols(7'd3);
		mat = '{3'b110, 3'b111, 3'b011, 3'b0, 3'b0, 3'b0, 3'b0, 3'b0, 3'b0};
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				send_cell(mat[r][2-k], r == 2 && k == 2);
		// one-cell matrices, last cell within a row
		send_cell(1'b1, 1'b1);
		send_cell(1'b0, 1'b1);
		// zero width acts as one column
		write_cols(7'd0);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b1);
		// width above the maximum acts as the maximum
		write_cols(7'd127);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b0);
		send_cell(1'b0, 1'b0);
		send_cell(1'b1, 1'b1);
		// width lowered mid-row
		write_cols(7'd8);
		repeat (5) send_cell(1'b1, 1'b0);
		write_cols(7'd2);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b1);

		// height saturation in a single column
		write_cols(7'd1);
		repeat (ROWS_MAX + 6) send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b1);

		write_cols(7'd64);
		while (items_sent < ITEM_GOAL) begin
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 15))
					0: begin
						case ($urandom_range(0, 4))
							0: w = 0;
							1: w = 1;
							2: w = 64;
							3: w = 65;
							default: w = 127;
						endcase
					end
					1, 2, 3: w = $urandom_range(9, 127);
					default: w = $urandom_range(1, 8);
				endcase
				write_cols(w[6:0]);
			end
			n = (cur_cols == 0) ? 1 : (cur_cols > COLS_MAX) ? COLS_MAX : cur_cols;
			total = n * ((n > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6));
			if (total > 1 && $urandom_range(0, 5) == 0)
				total = $urandom_range(1, total - 1);
			split_at = (total > 1 && $urandom_range(0, 9) == 0)
				? $urandom_range(1, total - 1) : 0;
			density = $urandom_range(50, 98);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8))
					send_cell(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
			end
			for (int unsigned k = 0; k < total; k++) begin
				if (split_at != 0 && k == split_at) write_cols(7'($urandom_range(1, 8)));
				send_cell($urandom_range(0, 99) < density, k == total - 1);
			end
		end

		start <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SWEEP_WAIT) @(negedge clk);
		while (sb.pending() != 0) begin
			void'(sb.area_q.pop_front());
			sb.flag("no max_area for a last_cell item");
		end
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
